// ===== rtl/glob_wildcard_matcher_top_defines.svh =====
// Assertion macros shared by the glob wildcard matcher checkers.
`ifndef GLOB_WILDCARD_MATCHER_TOP_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GLW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GLW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/glw_pkg.sv =====
// Shared types and constants for the glob wildcard matcher.
package glw_pkg;

  localparam logic [7:0] StarChar = 8'h2A;
  localparam logic [7:0] AnyChar  = 8'h3F;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int PatLenW  = 6;

  localparam logic [CfgIdxW-1:0] RegPat0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPat1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPat2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPat3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPatLen = 3'd4;

  typedef struct packed {
    logic cprop;  // closure through a star, current vector
    logic dprop;  // closure through a star, updated vector
    logic adv;    // literal or any-char advance into the next position
  } glw_link_t;

endpackage

// ===== rtl/glw_cell.sv =====
// One pattern position: active bit, star closure and character step.
module glw_cell
  import glw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       init_bit,
  input  logic       en,
  input  logic       has_char,
  input  logic [7:0] pat_char,
  input  logic [7:0] subject_char,
  input  logic       load,
  input  logic       rearm,
  input  glw_link_t  link_in,
  output glw_link_t  link_out,
  output logic       c,
  output logic       d
);

  logic active;
  logic is_star;
  logic is_match;
  logic n;

  assign is_star  = has_char && (pat_char == StarChar);
  assign is_match = has_char && !is_star &&
                    ((pat_char == AnyChar) || (pat_char == subject_char));

  assign c = en && (active || link_in.cprop);
  assign n = (is_star && c) || link_in.adv;
  assign d = en && (n || link_in.dprop);

  assign link_out.cprop = c && is_star;
  assign link_out.dprop = d && is_star;
  assign link_out.adv   = c && is_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= init_bit;
    end else if (rearm) begin
      active <= init_bit;
    end else if (load) begin
      active <= d;
    end
  end

endmodule

// ===== rtl/glw_skid.sv =====
// Output register with skid stage for the match result.
module glw_skid
  import glw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  input  logic res_matched,
  output logic ready,
  output logic out_valid,
  input  logic out_ready,
  output logic matched
);

  logic skid_valid;
  logic skid_matched;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        matched    <= skid_matched;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        matched   <= res_matched;
      end
    end else if (res_valid) begin
      skid_valid   <= 1'b1;
      skid_matched <= res_matched;
    end
  end

endmodule

// ===== rtl/glob_wildcard_matcher_top.sv =====
// Top level of the streamed glob wildcard matcher.
// Takes one subject character per cycle with no bubbles while the result side keeps up; in_ready
// drops only while the skid stage holds a result behind a stalled output register. A row of
// PATTERN_MAX+1 cells, one per pattern position, holds the active-position vector; each
// transaction that carries a character updates every cell at once, and the star closure ripples
// through the row twice in that cycle, which sets the clock period. A transaction with
// end_of_string gives its result on out_valid through an output register backed by a one-entry
// skid stage, and rearms the row. No clearing pass follows reset. Pattern registers are written
// through cfg_we/cfg_index/cfg_data.
module glob_wildcard_matcher_top
  import glw_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          subject_char,
  input  logic                char_present,
  input  logic                end_of_string,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                matched
);

  localparam int LenIdxW = $clog2(PATTERN_MAX + 1);

  logic [3:0][CfgDataW-1:0] pat_regs;
  logic [PatLenW-1:0]       pat_len;
  logic [PatLenW-1:0]       len_sat;
  logic [LenIdxW-1:0]       len_idx;
  logic                     accept;
  logic                     load;
  logic                     rearm;
  logic [PATTERN_MAX:0]     c_vec;
  logic [PATTERN_MAX:0]     d_vec;
  logic                     res_matched;
  glw_link_t                link [PATTERN_MAX:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_regs <= '0;
      pat_len  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPat0:   pat_regs[0] <= cfg_data;
        RegPat1:   pat_regs[1] <= cfg_data;
        RegPat2:   pat_regs[2] <= cfg_data;
        RegPat3:   pat_regs[3] <= cfg_data;
        RegPatLen: pat_len     <= cfg_data[PatLenW-1:0];
        default: ;
      endcase
    end
  end

  assign len_sat = (pat_len > PatLenW'(PATTERN_MAX)) ? PatLenW'(PATTERN_MAX) : pat_len;
  assign len_idx = len_sat[LenIdxW-1:0];

  assign accept = in_valid && in_ready;
  assign load   = accept && char_present;
  assign rearm  = accept && end_of_string;

  assign link[0] = '0;

  for (genvar i = 0; i <= PATTERN_MAX; i++) begin : g_cell
    if (i < PATTERN_MAX) begin : g_pos
      localparam int RegSel = i / 8;
      localparam int ByteSel = i % 8;
      glw_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .init_bit     (i == 0),
        .en           (len_sat >= PatLenW'(i)),
        .has_char     (len_sat > PatLenW'(i)),
        .pat_char     (pat_regs[RegSel][ByteSel*8 +: 8]),
        .subject_char (subject_char),
        .load         (load),
        .rearm        (rearm),
        .link_in      (link[i]),
        .link_out     (link[i+1]),
        .c            (c_vec[i]),
        .d            (d_vec[i])
      );
    end else begin : g_tail
      glw_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .init_bit     (i == 0),
        .en           (len_sat >= PatLenW'(i)),
        .has_char     (1'b0),
        .pat_char     (8'h00),
        .subject_char (subject_char),
        .load         (load),
        .rearm        (rearm),
        .link_in      (link[i]),
        .link_out     (),
        .c            (c_vec[i]),
        .d            (d_vec[i])
      );
    end
  end

  assign res_matched = char_present ? d_vec[len_idx] : c_vec[len_idx];

  glw_skid u_skid (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (rearm),
    .res_matched (res_matched),
    .ready       (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .matched     (matched)
  );

endmodule

// ===== rtl/glw_checker.sv =====
// Port-level checker for the glob wildcard matcher and its bind.
`include "glob_wildcard_matcher_top_defines.svh"

module glw_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic end_of_string,
  input logic out_valid,
  input logic out_ready,
  input logic matched
);

  `GLW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(matched), "result dropped or changed while stalled")
  `GLW_ASSERT_NOW(a_stall_needs_result, clk, rst, !in_ready, out_valid, "input stalled with no pending result")
  `GLW_ASSERT_NEXT(a_eos_gives_result, clk, rst, in_valid && in_ready && end_of_string && !out_valid, out_valid, "end-of-string transaction gave no result")
  `GLW_ASSERT_NEXT(a_no_invented_result, clk, rst, in_valid && in_ready && !end_of_string && !out_valid, !out_valid, "result without end-of-string")

endmodule

bind glob_wildcard_matcher_top glw_checker u_glw_checker (.*);
